>>> design/lsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the lease slot allocator.
// No dependencies; used by lsa_ctrl, lsa_dp and lease_slot_allocator_top.
package lsa_pkg;

   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_EXTEND = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_QUERY  = 2'd3;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STS_NO_ENTRY = 2'd2;

   localparam logic [1:0] CSR_RANGE_START   = 2'd0;
   localparam logic [1:0] CSR_RANGE_END     = 2'd1;
   localparam logic [1:0] CSR_LEASE_SECONDS = 2'd2;

   localparam logic [15:0] RESET_RANGE_START   = 16'd54400;
   localparam logic [15:0] RESET_RANGE_END     = 16'd54420;
   localparam logic [15:0] RESET_LEASE_SECONDS = 16'd120;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [30:0] owner_id;
      logic [15:0] slot_number;
   } lsa_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_number;
      logic [30:0] holder_id;
      logic        lease_expired;
   } lsa_rsp_type;

   typedef struct packed {
      logic        present;
      logic [30:0] holder;
      logic [31:0] stamp;
   } lsa_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOOKUP,
      ST_EVAL
   } lsa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic tick;
      logic scan_step;
      logic alloc_commit;
      logic alloc_fail;
      logic lookup_done;
   } lsa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic scan_hit;
      logic scan_fail;
   } lsa_sts_type;

endpackage

>>> design/lsa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the lease slot allocator: clearing pass, scan and lookup.
// Depends on lsa_pkg; drives lsa_dp through command/status structs.
module lsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_type,
   input  lsa_pkg::lsa_sts_type sts,
   output logic                busy,
   output lsa_pkg::lsa_cmd_type cmd
);

   lsa_pkg::lsa_state_type state_ff;
   lsa_pkg::lsa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsa_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = lsa_pkg::ST_IDLE;
         end
         lsa_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == lsa_pkg::REQ_ALLOC) state_in = lsa_pkg::ST_SCAN;
               else if (req_type != lsa_pkg::REQ_TICK) state_in = lsa_pkg::ST_LOOKUP;
            end
         end
         lsa_pkg::ST_SCAN: begin
            if (sts.scan_hit || sts.scan_fail) state_in = lsa_pkg::ST_IDLE;
         end
         lsa_pkg::ST_LOOKUP: begin
            state_in = lsa_pkg::ST_EVAL;
         end
         lsa_pkg::ST_EVAL: begin
            state_in = lsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = lsa_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         lsa_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         lsa_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
            cmd.tick   = start && (req_type == lsa_pkg::REQ_TICK);
         end
         lsa_pkg::ST_SCAN: begin
            cmd.scan_step    = 1'b1;
            cmd.alloc_commit = sts.scan_hit;
            cmd.alloc_fail   = !sts.scan_hit && sts.scan_fail;
         end
         lsa_pkg::ST_LOOKUP: begin
            cmd = '0;
         end
         lsa_pkg::ST_EVAL: begin
            cmd.lookup_done = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/lsa_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, second counter, cursor, lease table memory,
// scan pointers and result register. Depends on lsa_pkg; driven by lsa_ctrl.
module lsa_dp #(
   parameter int NUM_SLOTS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  lsa_pkg::lsa_req_type req_data,
   input  lsa_pkg::lsa_cmd_type cmd,
   output lsa_pkg::lsa_sts_type sts,
   output logic                 rsp_valid,
   output lsa_pkg::lsa_rsp_type rsp_data
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);

   logic [15:0] range_start_ff;
   logic [15:0] range_end_ff;
   logic [15:0] lease_ff;
   logic [31:0] seconds_ff;
   logic [IW-1:0] cursor_ff;
   logic [IW-1:0] clr_ff;

   lsa_pkg::lsa_req_type req_ff;
   logic [LW-1:0] len_ff;
   logic          in_range_ff;
   logic [IW-1:0] k_issue_ff;
   logic [LW-1:0] issue_cnt_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] k_chk_ff;
   logic          last_ff;
   lsa_pkg::lsa_entry_type rd_data_ff;
   logic          rsp_valid_ff;
   lsa_pkg::lsa_rsp_type rsp_ff;

   lsa_pkg::lsa_entry_type mem [NUM_SLOTS];

   logic [16:0]   diff;
   logic [16:0]   off;
   logic [LW-1:0] len_in;
   logic [IW-1:0] start_off;
   logic          in_range_in;
   logic [IW-1:0] k_issue_in;
   logic [IW-1:0] cursor_in;
   logic          expired;
   logic          hit;
   logic          ext_ok;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   lsa_pkg::lsa_entry_type mem_wdata;
   lsa_pkg::lsa_rsp_type rsp_in;

   // active length: end - start + 1, clamped to table size, zero when inverted
   assign diff = {1'b0, range_end_ff} - {1'b0, range_start_ff};
   always_comb begin
      if (range_end_ff < range_start_ff) len_in = '0;
      else if (diff >= 17'(NUM_SLOTS))   len_in = LW'(NUM_SLOTS);
      else                               len_in = LW'(diff + 17'd1);
   end

   // stale cursor past the active range restarts at slot zero
   assign start_off   = (LW'(cursor_ff) < len_in) ? cursor_ff : '0;
   assign off         = {1'b0, req_data.slot_number} - {1'b0, range_start_ff};
   assign in_range_in = (req_data.slot_number >= range_start_ff) && (off < 17'(len_in));

   assign k_issue_in = ((LW'(k_issue_ff) + LW'(1)) == len_ff) ? '0 : IW'(k_issue_ff + 1'b1);
   assign cursor_in  = ((LW'(k_chk_ff) + LW'(1)) == len_ff) ? '0 : IW'(k_chk_ff + 1'b1);

   assign expired = (seconds_ff - rd_data_ff.stamp) > {16'd0, lease_ff};
   assign hit     = rd_vld_ff && (!rd_data_ff.present || expired);
   assign ext_ok  = (req_ff.req_type == lsa_pkg::REQ_EXTEND) && in_range_ff
                    && rd_data_ff.present;

   assign sts.clear_last = (clr_ff == IW'(NUM_SLOTS - 1));
   assign sts.scan_hit   = hit;
   assign sts.scan_fail  = (len_ff == '0) || (rd_vld_ff && !hit && last_ff);

   always_comb begin
      mem_we    = cmd.clear_step || cmd.alloc_commit || (cmd.lookup_done && ext_ok);
      mem_waddr = k_issue_ff;
      mem_wdata.present = 1'b1;
      mem_wdata.holder  = req_ff.owner_id;
      mem_wdata.stamp   = seconds_ff;
      if (cmd.clear_step) begin
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.alloc_commit) begin
         mem_waddr = k_chk_ff;
      end
   end

   // one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[k_issue_ff];
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.alloc_commit) begin
         rsp_in.status         = lsa_pkg::STS_OK;
         rsp_in.granted_number = range_start_ff + 16'(k_chk_ff);
         rsp_in.holder_id      = req_ff.owner_id;
      end else if (cmd.alloc_fail) begin
         rsp_in.status = lsa_pkg::STS_NO_SLOT;
      end else begin
         rsp_in.granted_number = req_ff.slot_number;
         if (!in_range_ff || !rd_data_ff.present) begin
            rsp_in.status = lsa_pkg::STS_NO_ENTRY;
         end else if (ext_ok) begin
            rsp_in.status    = lsa_pkg::STS_OK;
            rsp_in.holder_id = req_ff.owner_id;
         end else begin
            rsp_in.status        = lsa_pkg::STS_OK;
            rsp_in.holder_id     = rd_data_ff.holder;
            rsp_in.lease_expired = expired;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= lsa_pkg::RESET_RANGE_START;
         range_end_ff   <= lsa_pkg::RESET_RANGE_END;
         lease_ff       <= lsa_pkg::RESET_LEASE_SECONDS;
         seconds_ff     <= '0;
         cursor_ff      <= '0;
         clr_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               lsa_pkg::CSR_RANGE_START:   range_start_ff <= csr_wdata;
               lsa_pkg::CSR_RANGE_END:     range_end_ff   <= csr_wdata;
               lsa_pkg::CSR_LEASE_SECONDS: lease_ff       <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.tick) seconds_ff <= seconds_ff + 32'd1;
         if (cmd.clear_step) clr_ff <= IW'(clr_ff + 1'b1);
         if (cmd.alloc_commit) cursor_ff <= cursor_in;

         if (cmd.accept) begin
            req_ff       <= req_data;
            len_ff       <= len_in;
            in_range_ff  <= in_range_in;
            k_issue_ff   <= (req_data.req_type == lsa_pkg::REQ_ALLOC) ? start_off
                                                                      : off[IW-1:0];
            issue_cnt_ff <= '0;
            rd_vld_ff    <= 1'b0;
         end else if (cmd.scan_step) begin
            // read one slot per cycle; its check follows in the next cycle
            if (issue_cnt_ff < len_ff) begin
               k_issue_ff   <= k_issue_in;
               issue_cnt_ff <= issue_cnt_ff + LW'(1);
               rd_vld_ff    <= 1'b1;
               k_chk_ff     <= k_issue_ff;
               last_ff      <= (issue_cnt_ff == (len_ff - LW'(1)));
            end else begin
               rd_vld_ff <= 1'b0;
            end
         end

         rsp_valid_ff <= cmd.alloc_commit || cmd.alloc_fail || cmd.lookup_done;
         if (cmd.alloc_commit || cmd.alloc_fail || cmd.lookup_done) rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/lease_slot_allocator_top.sv
`timescale 1ns / 1ps
// Lease slot allocator: round-robin lease table over a configured number range.
// Depends on lsa_pkg, lsa_ctrl and lsa_dp.
//
// Usage:
//   Request beat: req_data is taken at a clock edge with start high and busy low.
//   Allocate and extend/query return one beat on rsp_data, marked by rsp_valid
//   for a single cycle; the receiver cannot stall it. A tick returns nothing.
//   csr_we/csr_index/csr_wdata write range_start (0), range_end (1) and
//   lease_seconds (2) while the block is idle.
// Operation:
//   Allocate: the table memory is read one slot per cycle from the cursor, with
//   the check in the cycle after the read; the scan ends at the first free or
//   expired slot, or fails once every slot of the active range (at most
//   NUM_SLOTS) has been checked.
//   Extend/query: one memory read; busy in LOOKUP and EVAL, result registered after EVAL.
//   Tick: the second counter steps at accept; busy never rises.
// Reset:
//   After reset the block runs a clearing pass over all NUM_SLOTS table entries,
//   holding busy high; configuration writes are accepted throughout.
module lease_slot_allocator_top #(
   parameter int NUM_SLOTS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lsa_pkg::lsa_req_type req_data,
   output logic                 rsp_valid,
   output lsa_pkg::lsa_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   lsa_pkg::lsa_cmd_type cmd;
   lsa_pkg::lsa_sts_type sts;

   lsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   lsa_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a result beat only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without preceding work");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == lsa_pkg::REQ_TICK) |=> !rsp_valid)
      else $error("tick produced a result beat");

   a_work_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type != lsa_pkg::REQ_TICK) |=> busy)
      else $error("accepted request did not raise busy");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_commit, cmd.alloc_fail, cmd.lookup_done, cmd.clear_step}))
      else $error("conflicting datapath commands");

endmodule

>>> test/lease_slot_allocator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lease_slot_allocator_top: directed and random request beats
// with random gaps, checked against an in-bench lease table predictor. Depends on lsa_pkg.
module lease_slot_allocator_top_test;

   localparam int NUM_SLOTS = 32;
   localparam int RAND_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 102;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      int unsigned gap;
      lsa_pkg::lsa_req_type beat;
   } backlog_entry_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   lsa_pkg::lsa_req_type req_data = '0;
   logic                 rsp_valid;
   lsa_pkg::lsa_rsp_type rsp_data;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   lease_slot_allocator_top #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the block's registers and lease table
   logic [15:0] cfg_start = lsa_pkg::RESET_RANGE_START;
   logic [15:0] cfg_end   = lsa_pkg::RESET_RANGE_END;
   logic [15:0] cfg_lease = lsa_pkg::RESET_LEASE_SECONDS;
   bit          slot_used [NUM_SLOTS];
   logic [30:0] slot_owner [NUM_SLOTS];
   logic [31:0] slot_stamp [NUM_SLOTS];
   int unsigned cursor = 0;
   logic [31:0] secs_now = '0;

   backlog_entry_type    req_backlog [$];
   lsa_pkg::lsa_rsp_type pending_replies [$];
   bit                   req_taken = 1'b0;
   bit                   calm_phase = 1'b0;
   int unsigned          gap_left = 0;
   int unsigned          quiet_cycles = 0;
   int unsigned          mismatches = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned span_len();
      int unsigned n;
      if (cfg_end < cfg_start) return 0;
      n = 32'(cfg_end) - 32'(cfg_start) + 1;
      return (n > NUM_SLOTS) ? NUM_SLOTS : n;
   endfunction

   // age is taken modulo 2^32
   function automatic bit lease_stale(input int unsigned k);
      logic [31:0] age;
      age = secs_now - slot_stamp[k];
      return age > 32'(cfg_lease);
   endfunction

   task automatic predict_lease(input lsa_pkg::lsa_req_type r);
      int unsigned n, k, base, i;
      lsa_pkg::lsa_rsp_type res;
      bit hit;
      n = span_len();
      res = '0;
      hit = 1'b0;
      if (r.req_type == lsa_pkg::REQ_TICK) begin
         secs_now = secs_now + 32'd1;
         return;
      end
      if (r.req_type == lsa_pkg::REQ_ALLOC) begin
         res.status = lsa_pkg::STS_NO_SLOT;
         // stale cursor after a range change restarts at slot 0
         base = (cursor < n) ? cursor : 0;
         for (i = 0; i < n && !hit; i++) begin
            k = base + i;
            if (k >= n) k = k - n;
            if (!slot_used[k] || lease_stale(k)) begin
               hit = 1'b1;
               slot_used[k] = 1'b1;
               slot_owner[k] = r.owner_id;
               slot_stamp[k] = secs_now;
               cursor = (k + 1 < n) ? k + 1 : 0;
               res.status = lsa_pkg::STS_OK;
               res.granted_number = cfg_start + 16'(k);
               res.holder_id = r.owner_id;
            end
         end
      end else begin
         res.status = lsa_pkg::STS_NO_ENTRY;
         res.granted_number = r.slot_number;
         if (r.slot_number >= cfg_start) begin
            k = 32'(r.slot_number) - 32'(cfg_start);
            if (k < n && slot_used[k]) begin
               res.status = lsa_pkg::STS_OK;
               if (r.req_type == lsa_pkg::REQ_EXTEND) begin
                  // extend takes over the entry even when expired
                  slot_owner[k] = r.owner_id;
                  slot_stamp[k] = secs_now;
                  res.holder_id = r.owner_id;
               end else begin
                  res.holder_id = slot_owner[k];
                  res.lease_expired = lease_stale(k);
               end
            end
         end
      end
      pending_replies.insert(pending_replies.size(), res);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_reply(input lsa_pkg::lsa_rsp_type got);
      lsa_pkg::lsa_rsp_type want;
      if (pending_replies.size() == 0) begin
         $error("response beat with none outstanding: status %0d number %0d",
                got.status, got.granted_number);
         mismatches++;
         return;
      end
      want = pending_replies.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("granted_number", 32'(want.granted_number), 32'(got.granted_number));
      check_field("holder_id", 32'(want.holder_id), 32'(got.holder_id));
      check_field("lease_expired", 32'(want.lease_expired), 32'(got.lease_expired));
   endtask

   // driver: request beats change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (req_taken) begin
            void'(req_backlog.pop_front());
            gap_left = (req_backlog.size() != 0) ? req_backlog[0].gap : 0;
         end
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            start <= 1'b1;
            req_data <= req_backlog[0].beat;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: responses checked before the new beat is predicted
   always @(posedge clock) begin
      req_taken = !reset && start && !busy;
      if (!reset && rsp_valid) check_reply(rsp_data);
      if (req_taken) predict_lease(req_data);
      if (req_taken || (!reset && rsp_valid)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int unsigned next_gap();
      int unsigned p;
      if (calm_phase) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_req(input logic [1:0] kind, input logic [30:0] owner,
                          input logic [15:0] slot);
      backlog_entry_type e;
      e.gap = next_gap();
      e.beat.req_type = kind;
      e.beat.owner_id = owner;
      e.beat.slot_number = slot;
      req_backlog.insert(req_backlog.size(), e);
   endtask

   task automatic add_random_req();
      int unsigned n, p;
      logic [1:0] kind;
      logic [30:0] owner;
      logic [15:0] slot;
      n = span_len();
      p = $urandom_range(0, 99);
      if (p < 35) kind = lsa_pkg::REQ_ALLOC;
      else if (p < 55) kind = lsa_pkg::REQ_EXTEND;
      else if (p < 75) kind = lsa_pkg::REQ_TICK;
      else kind = lsa_pkg::REQ_QUERY;
      p = $urandom_range(0, 19);
      if (p == 0) owner = '0;
      else if (p == 1) owner = '1;
      else owner = 31'($urandom());
      // mostly numbers in or just around the active range
      p = $urandom_range(0, 99);
      if (p < 75) slot = cfg_start + 16'($urandom_range(0, n + 1));
      else if (p < 85) slot = cfg_start - 16'd1;
      else slot = 16'($urandom_range(0, 65535));
      add_req(kind, owner, slot);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         lsa_pkg::CSR_RANGE_START:   cfg_start = val;
         lsa_pkg::CSR_RANGE_END:     cfg_end = val;
         lsa_pkg::CSR_LEASE_SECONDS: cfg_lease = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_config(input int unsigned s, input int unsigned e, input int unsigned l);
      write_csr(lsa_pkg::CSR_RANGE_START, 16'(s));
      write_csr(lsa_pkg::CSR_RANGE_END, 16'(e));
      write_csr(lsa_pkg::CSR_LEASE_SECONDS, 16'(l));
   endtask

   task automatic pick_config(input int ph);
      int unsigned s, e, l, p;
      case (ph)
         0: apply_config(0, 65535, 65535);
         1: apply_config(65535, 65535, 1);
         2: apply_config(65504, 65535, 2);
         3: apply_config(20, 19, 3);
         4: apply_config(0, 0, 1);
         default: begin
            p = $urandom_range(0, 9);
            if (p < 3) s = lsa_pkg::RESET_RANGE_START;
            else if (p < 6) s = $urandom_range(0, 40);
            else s = $urandom_range(0, 65535);
            p = $urandom_range(0, 99);
            if (p < 10 && s > 0) begin
               e = s - 1;
            end else if (p < 25) begin
               e = 65535;
            end else begin
               e = s + $urandom_range(0, 40);
               if (e > 65535) e = 65535;
            end
            p = $urandom_range(0, 99);
            if (p < 60) l = $urandom_range(1, 6);
            else if (p < 80) l = $urandom_range(7, 40);
            else if (p < 90) l = 65535;
            else l = $urandom_range(1, 65535);
            apply_config(s, e, l);
         end
      endcase
   endtask

   // registers are only touched once every response is back and the block is quiet
   task automatic settle();
      while (req_backlog.size() != 0 || pending_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset range 54400..54420, lease 120
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54400);
      add_req(lsa_pkg::REQ_EXTEND, 31'd5, 16'd54400);
      add_req(lsa_pkg::REQ_ALLOC, 31'd0, 16'd0);
      add_req(lsa_pkg::REQ_ALLOC, 31'h7FFF_FFFF, 16'hFFFF);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54401);
      add_req(lsa_pkg::REQ_EXTEND, 31'h2AAA_AAAA, 16'd54400);
      add_req(lsa_pkg::REQ_TICK, 31'h5555_5555, 16'h5555);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54400);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54420);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54421);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd54399);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd0);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd65535);
      add_req(lsa_pkg::REQ_EXTEND, 31'd1, 16'd65535);
      settle();

      // short range, lease 1: fill, fail, expire, extend an expired entry, reclaim
      apply_config(100, 103, 1);
      add_req(lsa_pkg::REQ_ALLOC, 31'd11, 16'd0);
      add_req(lsa_pkg::REQ_ALLOC, 31'd12, 16'd0);
      add_req(lsa_pkg::REQ_ALLOC, 31'd13, 16'd0);
      add_req(lsa_pkg::REQ_ALLOC, 31'd14, 16'd0);
      add_req(lsa_pkg::REQ_ALLOC, 31'd15, 16'd0);
      add_req(lsa_pkg::REQ_TICK, 31'd0, 16'd0);
      add_req(lsa_pkg::REQ_TICK, 31'd0, 16'd0);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd100);
      add_req(lsa_pkg::REQ_EXTEND, 31'd21, 16'd100);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd100);
      add_req(lsa_pkg::REQ_ALLOC, 31'd22, 16'd0);
      settle();

      // empty range
      apply_config(10, 5, 1);
      add_req(lsa_pkg::REQ_ALLOC, 31'd30, 16'd0);
      add_req(lsa_pkg::REQ_EXTEND, 31'd31, 16'd7);
      add_req(lsa_pkg::REQ_QUERY, 31'd0, 16'd10);
      settle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         pick_config(ph);
         calm_phase = ($urandom_range(0, 3) == 0);
         repeat (ITEMS_PER_PHASE) add_random_req();
         settle();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
